### hdl/rti_pkg.sv
// shared constants and types for the ray/triangle intersection block
`default_nettype none

package rti_pkg;

   // default coordinate format, signed Q16.16
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_Z    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_DET  = 3'd6;

   // sideband that travels with a transaction through the divider
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

endpackage

`default_nettype wire

### hdl/rti_div.sv
// pipelined restoring divider with saturation, one quotient bit per stage
`default_nettype none

module rti_div #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF,
   parameter int SUM_WIDTH   = 3 * rti_pkg::COORD_WIDTH_DEF + 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rti_pkg::ctl_type                  in_ctl,
   input  wire logic [SUM_WIDTH-2:0]              in_det,
   input  wire logic [SUM_WIDTH-2+FRAC_BITS:0]    in_num,
   output      rti_pkg::ctl_type                  out_ctl,
   output      logic [COORD_WIDTH-2:0]            out_quo
);

   localparam int DETW  = SUM_WIDTH - 1;
   localparam int NUMW  = SUM_WIDTH - 1 + FRAC_BITS;
   localparam int CMPW  = DETW + COORD_WIDTH + FRAC_BITS;
   localparam int STEPS = COORD_WIDTH - 1;

   rti_pkg::ctl_type        ctl_ff [0:STEPS];
   logic [DETW-1:0]         det_ff [0:STEPS];
   logic [NUMW-1:0]         rem_ff [0:STEPS];
   logic [COORD_WIDTH-2:0]  quo_ff [0:STEPS];
   logic                    sat_ff [0:STEPS];
   logic                    sat_in;

   // first stage: quotient at or above full scale saturates
   always_comb begin
      sat_in = CMPW'(in_num) >= (CMPW'(in_det) << STEPS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
      end
      det_ff[0] <= in_det;
      rem_ff[0] <= in_num;
      quo_ff[0] <= '0;
      sat_ff[0] <= sat_in;
   end

   // one trial subtract per stage, most significant quotient bit first
   for (genvar j = 1; j <= STEPS; j++) begin : g_step
      localparam int B = STEPS - j;
      logic [CMPW-1:0]        trial;
      logic                   take;
      logic [NUMW-1:0]        rem_in;
      logic [COORD_WIDTH-2:0] quo_in;

      always_comb begin
         trial     = CMPW'(det_ff[j-1]) << B;
         take      = CMPW'(rem_ff[j-1]) >= trial;
         rem_in    = take ? NUMW'(CMPW'(rem_ff[j-1]) - trial) : rem_ff[j-1];
         quo_in    = quo_ff[j-1];
         quo_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
         det_ff[j] <= det_ff[j-1];
         rem_ff[j] <= rem_in;
         quo_ff[j] <= quo_in;
         sat_ff[j] <= sat_ff[j-1];
      end
   end

   // saturated quotient is the largest distance
   assign out_ctl = ctl_ff[STEPS];
   assign out_quo = sat_ff[STEPS] ? '1 : quo_ff[STEPS];

endmodule

`default_nettype wire

### hdl/ray_triangle_intersect.sv
// top level: ray/triangle intersection pipeline with culling and hit point
`default_nettype none

// Tests one triangle per clock against the configured ray. A triangle is taken
// at each rising edge with start high and busy low; busy is high only during
// reset. Every transaction gives exactly one result, shown for one cycle on
// rsp_strobe. The pipeline holds the restoring divider for the distance, one
// stage per quotient bit, behind seven stages of edge, cross product and dot
// product arithmetic and two stages for the hit point. The receiver cannot
// hold results off, so it must take every strobe. Write the ray registers only
// while no transaction is in flight.
module ray_triangle_intersect #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // triangle input
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex0_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex0_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex0_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex1_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex1_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex1_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex2_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex2_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vertex2_z,
   // result output
   output      logic                                  rsp_strobe,
   output      logic                                  rsp_hit,
   output      logic [COORD_WIDTH-2:0]                rsp_distance,
   output      logic signed [COORD_WIDTH-1:0]         rsp_point_x,
   output      logic signed [COORD_WIDTH-1:0]         rsp_point_y,
   output      logic signed [COORD_WIDTH-1:0]         rsp_point_z,
   // register writes
   input  wire logic                                  csr_write_en,
   input  wire logic [rti_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [COORD_WIDTH-1:0]                csr_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int EW   = CW + 1;             // edge and origin offset
   localparam int PRW  = 2 * EW;             // cross product term
   localparam int LW   = 2 * CW + 3;         // cross product vector
   localparam int PLW  = CW + 1 + EW;        // low partial product
   localparam int PHW  = LW - CW + EW;       // high partial product
   localparam int SW   = 3 * CW + 6;         // dot product
   localparam int TW   = (SW > CW + 2 * FRAC_BITS ? SW : CW + 2 * FRAC_BITS) + 1;
   localparam int NUMW = SW - 1 + FRAC_BITS;
   localparam int MW   = 2 * CW;             // hit point product
   localparam int LATENCY = CW + 9;

   logic accept;

   // ray registers
   logic signed [CW-1:0] org_ff [3];
   logic signed [CW-1:0] dir_ff [3];
   logic [CW-2:0]        min_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
         min_det_ff <= (CW-1)'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            rti_pkg::REG_ORIGIN_X: org_ff[0]  <= csr_data;
            rti_pkg::REG_ORIGIN_Y: org_ff[1]  <= csr_data;
            rti_pkg::REG_ORIGIN_Z: org_ff[2]  <= csr_data;
            rti_pkg::REG_DIR_X:    dir_ff[0]  <= csr_data;
            rti_pkg::REG_DIR_Y:    dir_ff[1]  <= csr_data;
            rti_pkg::REG_DIR_Z:    dir_ff[2]  <= csr_data;
            rti_pkg::REG_MIN_DET:  min_det_ff <= csr_data[CW-2:0];
            default: ;
         endcase
      end
   end

   assign busy   = reset;
   assign accept = start && !busy;

   // stage valid bits for the arithmetic ahead of the divider
   logic [5:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], accept};
      end
   end

   // stage 1: edges and origin offset
   logic signed [CW-1:0] v0 [3];
   logic signed [CW-1:0] v1 [3];
   logic signed [CW-1:0] v2 [3];
   logic signed [EW-1:0] dir_ext [3];
   logic signed [EW-1:0] e1_in [3];
   logic signed [EW-1:0] e2_in [3];
   logic signed [EW-1:0] tv_in [3];
   logic signed [EW-1:0] e1_s1_ff [3];
   logic signed [EW-1:0] e2_s1_ff [3];
   logic signed [EW-1:0] tv_s1_ff [3];

   assign v0[0] = req_vertex0_x;
   assign v0[1] = req_vertex0_y;
   assign v0[2] = req_vertex0_z;
   assign v1[0] = req_vertex1_x;
   assign v1[1] = req_vertex1_y;
   assign v1[2] = req_vertex1_z;
   assign v2[0] = req_vertex2_x;
   assign v2[1] = req_vertex2_y;
   assign v2[2] = req_vertex2_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_ext[i] = EW'(dir_ff[i]);
         e1_in[i]   = EW'(v1[i]) - EW'(v0[i]);
         e2_in[i]   = EW'(v2[i]) - EW'(v0[i]);
         tv_in[i]   = EW'(org_ff[i]) - EW'(v0[i]);
      end
   end

   always_ff @(posedge clock) begin
      e1_s1_ff <= e1_in;
      e2_s1_ff <= e2_in;
      tv_s1_ff <= tv_in;
   end

   // stage 2: cross product terms, pvec = dir x e2 and qvec = tv x e1
   logic signed [PRW-1:0] cp_in [12];
   logic signed [PRW-1:0] cp_ff [12];
   logic signed [EW-1:0]  e1_s2_ff [3];
   logic signed [EW-1:0]  e2_s2_ff [3];
   logic signed [EW-1:0]  tv_s2_ff [3];

   always_comb begin
      cp_in[0]  = dir_ext[1] * e2_s1_ff[2];
      cp_in[1]  = dir_ext[2] * e2_s1_ff[1];
      cp_in[2]  = dir_ext[2] * e2_s1_ff[0];
      cp_in[3]  = dir_ext[0] * e2_s1_ff[2];
      cp_in[4]  = dir_ext[0] * e2_s1_ff[1];
      cp_in[5]  = dir_ext[1] * e2_s1_ff[0];
      cp_in[6]  = tv_s1_ff[1] * e1_s1_ff[2];
      cp_in[7]  = tv_s1_ff[2] * e1_s1_ff[1];
      cp_in[8]  = tv_s1_ff[2] * e1_s1_ff[0];
      cp_in[9]  = tv_s1_ff[0] * e1_s1_ff[2];
      cp_in[10] = tv_s1_ff[0] * e1_s1_ff[1];
      cp_in[11] = tv_s1_ff[1] * e1_s1_ff[0];
   end

   always_ff @(posedge clock) begin
      cp_ff    <= cp_in;
      e1_s2_ff <= e1_s1_ff;
      e2_s2_ff <= e2_s1_ff;
      tv_s2_ff <= tv_s1_ff;
   end

   // stage 3: cross product vectors, pvec in 0..2 and qvec in 3..5
   logic signed [LW-1:0] crs_in [6];
   logic signed [LW-1:0] crs_ff [6];
   logic signed [EW-1:0] e1_s3_ff [3];
   logic signed [EW-1:0] e2_s3_ff [3];
   logic signed [EW-1:0] tv_s3_ff [3];

   always_comb begin
      for (int c = 0; c < 6; c++) begin
         crs_in[c] = LW'(cp_ff[2*c]) - LW'(cp_ff[2*c+1]);
      end
   end

   always_ff @(posedge clock) begin
      crs_ff   <= crs_in;
      e1_s3_ff <= e1_s2_ff;
      e2_s3_ff <= e2_s2_ff;
      tv_s3_ff <= tv_s2_ff;
   end

   // stage 4: dot product terms split into two partial products each
   // rows: det = e1.pvec, u = tv.pvec, v = dir.qvec, s = e2.qvec
   logic signed [EW-1:0]  sa [4][3];
   logic signed [LW-1:0]  lb [4][3];
   logic signed [PLW-1:0] pplo_in [4][3];
   logic signed [PHW-1:0] pphi_in [4][3];
   logic signed [PLW-1:0] pplo_ff [4][3];
   logic signed [PHW-1:0] pphi_ff [4][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sa[0][i] = e1_s3_ff[i];
         lb[0][i] = crs_ff[i];
         sa[1][i] = tv_s3_ff[i];
         lb[1][i] = crs_ff[i];
         sa[2][i] = dir_ext[i];
         lb[2][i] = crs_ff[3+i];
         sa[3][i] = e2_s3_ff[i];
         lb[3][i] = crs_ff[3+i];
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            pplo_in[k][i] = $signed({1'b0, lb[k][i][CW-1:0]}) * sa[k][i];
            pphi_in[k][i] = $signed(lb[k][i][LW-1:CW]) * sa[k][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pplo_ff <= pplo_in;
      pphi_ff <= pphi_in;
   end

   // stage 5: recombine partial products
   logic signed [SW-1:0] term_in [4][3];
   logic signed [SW-1:0] term_ff [4][3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            term_in[k][i] = (SW'(pphi_ff[k][i]) <<< CW) + SW'(pplo_ff[k][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   // stage 6: dot product sums
   logic signed [SW-1:0] dot_in [4];
   logic signed [SW-1:0] dot_ff [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         dot_in[k] = term_ff[k][0] + term_ff[k][1] + term_ff[k][2];
      end
   end

   always_ff @(posedge clock) begin
      dot_ff <= dot_in;
   end

   // stage 7: culling and barycentric tests, divider operands
   logic signed [TW-1:0]   min_det_sh;
   logic signed [SW:0]     uv_sum;
   logic                   hit_in;
   logic [SW-2:0]          det_in;
   logic [NUMW-1:0]        num_in;
   rti_pkg::ctl_type       ctl_s7_ff;
   logic [SW-2:0]          det_s7_ff;
   logic [NUMW-1:0]        num_s7_ff;

   assign min_det_sh = $signed({{(TW-CW+1-2*FRAC_BITS){1'b0}}, min_det_ff,
                                {(2*FRAC_BITS){1'b0}}});

   always_comb begin
      uv_sum = (SW+1)'(dot_ff[1]) + (SW+1)'(dot_ff[2]);
      hit_in = (TW'(dot_ff[0]) >= min_det_sh)
            && !dot_ff[0][SW-1] && (|dot_ff[0])
            && !dot_ff[1][SW-1] && (dot_ff[1] <= dot_ff[0])
            && !dot_ff[2][SW-1] && (uv_sum <= (SW+1)'(dot_ff[0]))
            && !dot_ff[3][SW-1];
      det_in = dot_ff[0][SW-2:0];
      num_in = {dot_ff[3][SW-2:0], {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s7_ff <= '0;
      end else begin
         ctl_s7_ff <= '{valid: vld_ff[5], hit: hit_in};
      end
      det_s7_ff <= det_in;
      num_s7_ff <= num_in;
   end

   // distance = floor(s * 2^frac / det), saturated
   rti_pkg::ctl_type    div_ctl;
   logic [CW-2:0]       div_quo;

   rti_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .SUM_WIDTH   (SW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (ctl_s7_ff),
      .in_det  (det_s7_ff),
      .in_num  (num_s7_ff),
      .out_ctl (div_ctl),
      .out_quo (div_quo)
   );

   // hit point product dir * distance
   logic signed [MW-1:0] pmul_in [3];
   logic signed [MW-1:0] pmul_ff [3];
   rti_pkg::ctl_type     pt_ctl_ff;
   logic [CW-2:0]        pt_quo_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pmul_in[i] = dir_ff[i] * $signed({1'b0, div_quo});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ctl_ff <= '0;
      end else begin
         pt_ctl_ff <= div_ctl;
      end
      pmul_ff   <= pmul_in;
      pt_quo_ff <= div_quo;
   end

   // output stage: origin plus floored offset, saturate, zero on a miss
   localparam logic signed [MW:0] PMAX = $signed({{(MW-CW+2){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [MW:0] PMIN = ~PMAX;

   logic signed [MW-1:0] pshift [3];
   logic signed [MW:0]   psum [3];
   logic signed [CW-1:0] point_in [3];
   logic [CW-2:0]        dist_in;
   logic                 rsp_hit_in;
   logic                 rsp_strobe_ff;
   logic                 rsp_hit_ff;
   logic [CW-2:0]        rsp_dist_ff;
   logic signed [CW-1:0] rsp_point_ff [3];

   always_comb begin
      rsp_hit_in = pt_ctl_ff.hit;
      dist_in    = rsp_hit_in ? pt_quo_ff : '0;
      for (int i = 0; i < 3; i++) begin
         pshift[i] = pmul_ff[i] >>> FRAC_BITS;
         psum[i]   = (MW+1)'(org_ff[i]) + (MW+1)'(pshift[i]);
         if (!rsp_hit_in) begin
            point_in[i] = '0;
         end else if (psum[i] > PMAX) begin
            point_in[i] = PMAX[CW-1:0];
         end else if (psum[i] < PMIN) begin
            point_in[i] = PMIN[CW-1:0];
         end else begin
            point_in[i] = psum[i][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= pt_ctl_ff.valid;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_dist_ff  <= dist_in;
      rsp_point_ff <= point_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_point_x  = rsp_point_ff[0];
   assign rsp_point_y  = rsp_point_ff[1];
   assign rsp_point_z  = rsp_point_ff[2];

   // every taken triangle comes out after the full pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result missing after pipeline latency");

   // no result without a triangle taken the full pipeline depth before
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   // a miss carries an all-zero payload
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_distance == '0 && rsp_point_x == '0
                                    && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("miss with nonzero payload");

endmodule

`default_nettype wire

### dv/ray_triangle_intersect_tb.sv
// testbench for the ray/triangle intersection block: directed and random triangles, self-checked
`default_nettype none

module ray_triangle_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW      = 32;
   localparam int FB      = 16;
   localparam int WDOG    = 20000;
   localparam int SETTLE  = 60;
   localparam int MAX_MSG = 10;

   // register index that maps to no register
   localparam logic [rti_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [159:0]   wide_type;
   typedef struct packed { wide_type x, y, z; } vec_type;
   typedef struct packed { coord_type x, y, z; } pt_type;
   typedef struct packed { pt_type v0, v1, v2; } tri_type;
   typedef struct packed {
      logic          hit;
      logic [CW-2:0] distance;
      pt_type        pt;
   } hit_type;
   typedef struct {
      tri_type shape;
      bit      typed;
      hit_type res;
   } row_type;

   logic clock = 0, reset = 1;
   logic start = 0;
   logic busy;
   tri_type req = '0;
   logic rsp_strobe, rsp_hit;
   logic [CW-2:0] rsp_distance;
   coord_type rsp_point_x, rsp_point_y, rsp_point_z;
   logic csr_write_en = 0;
   logic [rti_pkg::CSR_INDEX_WIDTH-1:0] csr_index = rti_pkg::REG_ORIGIN_X;
   logic [CW-1:0] csr_data = '0;

   ray_triangle_intersect dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex0_x(req.v0.x), .req_vertex0_y(req.v0.y), .req_vertex0_z(req.v0.z),
      .req_vertex1_x(req.v1.x), .req_vertex1_y(req.v1.y), .req_vertex1_z(req.v1.z),
      .req_vertex2_x(req.v2.x), .req_vertex2_y(req.v2.y), .req_vertex2_z(req.v2.z),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_distance(rsp_distance),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow copy of the ray registers
   pt_type        ray_org = '0;
   pt_type        ray_dir = '0;
   logic [CW-2:0] ray_min_det = (CW-1)'(1);

   hit_type pending_hits[$];
   int      mismatches = 0;
   int      idle_cycles = 0;

   function automatic wide_type widen(coord_type a);
      return wide_type'(a);
   endfunction

   function automatic vec_type to_vec(pt_type p);
      vec_type r;
      r.x = widen(p.x); r.y = widen(p.y); r.z = widen(p.z);
      return r;
   endfunction

   function automatic vec_type vsub(vec_type a, vec_type b);
      vec_type r;
      r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
      return r;
   endfunction

   function automatic vec_type cross3(vec_type a, vec_type b);
      vec_type r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
   endfunction

   function automatic wide_type dot(vec_type a, vec_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   function automatic coord_type clamp_coord(wide_type p);
      wide_type hi, lo;
      hi = 160'sd2147483647;
      lo = -hi - 1;
      if (p > hi) return coord_type'(hi[CW-1:0]);
      if (p < lo) return coord_type'(lo[CW-1:0]);
      return coord_type'(p[CW-1:0]);
   endfunction

   // culled moller-trumbore test in exact integers
   function automatic hit_type predict(tri_type t);
      hit_type  r;
      vec_type  v0, e1, e2, tv, d, pv, qv, o;
      wide_type det, u, v, s, q, floor_det, dmax;
      r = '0;
      dmax = 160'sd2147483647;
      v0 = to_vec(t.v0);
      e1 = vsub(to_vec(t.v1), v0);
      e2 = vsub(to_vec(t.v2), v0);
      o  = to_vec(ray_org);
      d  = to_vec(ray_dir);
      tv = vsub(o, v0);
      pv = cross3(d, e2);
      det = dot(e1, pv);
      floor_det = '0;
      floor_det[CW-2:0] = ray_min_det;
      floor_det = floor_det <<< (2 * FB);
      if (det < floor_det || det <= 0) return r;
      u = dot(tv, pv);
      if (u < 0 || u > det) return r;
      qv = cross3(tv, e1);
      v = dot(d, qv);
      if (v < 0 || u + v > det) return r;
      s = dot(e2, qv);
      if (s < 0) return r;
      q = (s <<< FB) / det;
      if (q > dmax) q = dmax;
      r.hit      = 1'b1;
      r.distance = q[CW-2:0];
      r.pt.x = clamp_coord(o.x + ((d.x * q) >>> FB));
      r.pt.y = clamp_coord(o.y + ((d.y * q) >>> FB));
      r.pt.z = clamp_coord(o.z + ((d.z * q) >>> FB));
      return r;
   endfunction

   // register write, enable left high for back-to-back writes
   task automatic csr_write(logic [rti_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      case (idx)
         rti_pkg::REG_ORIGIN_X: ray_org.x = val;
         rti_pkg::REG_ORIGIN_Y: ray_org.y = val;
         rti_pkg::REG_ORIGIN_Z: ray_org.z = val;
         rti_pkg::REG_DIR_X:    ray_dir.x = val;
         rti_pkg::REG_DIR_Y:    ray_dir.y = val;
         rti_pkg::REG_DIR_Z:    ray_dir.z = val;
         rti_pkg::REG_MIN_DET:  ray_min_det = val[CW-2:0];
         default: ;
      endcase
   endtask

   task automatic set_ray(pt_type org, pt_type dir, logic [CW-2:0] mind);
      csr_write(rti_pkg::REG_ORIGIN_X, org.x);
      csr_write(rti_pkg::REG_ORIGIN_Y, org.y);
      csr_write(rti_pkg::REG_ORIGIN_Z, org.z);
      csr_write(rti_pkg::REG_DIR_X, dir.x);
      csr_write(rti_pkg::REG_DIR_Y, dir.y);
      csr_write(rti_pkg::REG_DIR_Z, dir.z);
      csr_write(rti_pkg::REG_MIN_DET, {1'b0, mind});
      csr_write_en <= 1'b0;
   endtask

   // hold off until the pipeline is empty
   task automatic drain();
      start <= 1'b0;
      wait (pending_hits.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(100, 20);
   endfunction

   // one transaction; expectation queued at the accepting edge
   task automatic send(tri_type t, bit typed, hit_type res, bit allow_gap);
      int gap;
      req   <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_hits.push_back(typed ? res : predict(t));
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic coord_type sat64(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return coord_type'(v);
   endfunction

   // triangle placed around a point on the ray, random winding and size
   function automatic tri_type around_ray(int spread, bit far_out);
      tri_type t;
      longint tt, cx, cy, cz;
      tt = far_out ? longint'($urandom_range(32'h7fffffff))
                   : longint'($urandom_range(60 << FB));
      if ($urandom_range(9) == 0) tt = -tt;
      cx = longint'(ray_org.x) + ((longint'(ray_dir.x) * tt) >>> FB);
      cy = longint'(ray_org.y) + ((longint'(ray_dir.y) * tt) >>> FB);
      cz = longint'(ray_org.z) + ((longint'(ray_dir.z) * tt) >>> FB);
      t.v0.x = sat64(cx + $signed($urandom_range(2 * spread)) - spread);
      t.v0.y = sat64(cy + $signed($urandom_range(2 * spread)) - spread);
      t.v0.z = sat64(cz + $signed($urandom_range(2 * spread)) - spread);
      t.v1.x = sat64(cx + $signed($urandom_range(2 * spread)) - spread);
      t.v1.y = sat64(cy + $signed($urandom_range(2 * spread)) - spread);
      t.v1.z = sat64(cz + $signed($urandom_range(2 * spread)) - spread);
      t.v2.x = sat64(cx + $signed($urandom_range(2 * spread)) - spread);
      t.v2.y = sat64(cy + $signed($urandom_range(2 * spread)) - spread);
      t.v2.z = sat64(cz + $signed($urandom_range(2 * spread)) - spread);
      return t;
   endfunction

   function automatic pt_type rand_pt(int mag);
      pt_type p;
      p.x = $signed($urandom_range(2 * mag)) - mag;
      p.y = $signed($urandom_range(2 * mag)) - mag;
      p.z = $signed($urandom_range(2 * mag)) - mag;
      return p;
   endfunction

   function automatic coord_type edge_val();
      case ($urandom_range(3))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic coord_type q(int whole);
      return coord_type'(whole) <<< FB;
   endfunction

   function automatic tri_type mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
      tri_type t;
      t.v0 = '{q(ax), q(ay), q(az)};
      t.v1 = '{q(bx), q(by), q(bz)};
      t.v2 = '{q(cx), q(cy), q(cz)};
      return t;
   endfunction

   // result check against the oldest expectation
   always @(posedge clock) begin
      hit_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_hit, rsp_distance, '{rsp_point_x, rsp_point_y, rsp_point_z}};
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_MSG)
               $display("unexpected result: hit=%0d dist=%h pt=%h %h %h", got.hit,
                        got.distance, got.pt.x, got.pt.y, got.pt.z);
         end else begin
            want = pending_hits.pop_front();
            if (got.hit !== want.hit || got.distance !== want.distance ||
                got.pt.x !== want.pt.x || got.pt.y !== want.pt.y ||
                got.pt.z !== want.pt.z) begin
               mismatches++;
               if (mismatches <= MAX_MSG)
                  $display({"mismatch: exp hit=%0d dist=%h pt=%h %h %h, ",
                            "got hit=%0d dist=%h pt=%h %h %h"},
                           want.hit, want.distance, want.pt.x, want.pt.y, want.pt.z,
                           got.hit, got.distance, got.pt.x, got.pt.y, got.pt.z);
            end
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
         $display("ray_triangle_intersect_tb: FAIL");
         $finish;
      end
   end

   initial begin
      row_type reset_rows[$];
      row_type shape_rows[$];
      hit_type miss;
      tri_type t;
      pt_type  o, d;
      logic [CW-2:0] md;
      int   spread;
      miss = '0;

      // extremes under the reset ray: zero direction, every triangle misses
      reset_rows.push_back('{tri_type'('0), 1'b1, miss});
      reset_rows.push_back('{tri_type'({9{32'h7fffffff}}), 1'b1, miss});
      reset_rows.push_back('{tri_type'({9{32'h80000000}}), 1'b1, miss});
      reset_rows.push_back('{tri_type'({3{32'h80000000, 32'h7fffffff, 32'h80000000}}),
                             1'b1, miss});
      reset_rows.push_back('{mk_tri(-1, -1, 0, 0, 1, 0, 1, -1, 0), 1'b1, miss});

      // ray down +z from z=-5: front hit, back face, off the edges, behind origin, at a corner, far out, at the origin
      shape_rows.push_back('{mk_tri(-1, -1, 0, 0, 1, 0, 1, -1, 0), 1'b0, miss});
      shape_rows.push_back('{mk_tri(-1, -1, 0, 1, -1, 0, 0, 1, 0), 1'b0, miss});
      shape_rows.push_back('{mk_tri(2, -1, 0, 3, 1, 0, 4, -1, 0), 1'b0, miss});
      shape_rows.push_back('{mk_tri(-1, 2, 0, 0, 4, 0, 1, 2, 0), 1'b0, miss});
      shape_rows.push_back('{mk_tri(-1, -1, -9, 0, 1, -9, 1, -1, -9), 1'b0, miss});
      shape_rows.push_back('{mk_tri(0, 0, 3, 0, 1, 3, 1, 0, 3), 1'b0, miss});
      shape_rows.push_back('{mk_tri(-3000, -3000, 30000, 0, 3000, 30000, 3000, -3000, 30000),
                             1'b0, miss});
      shape_rows.push_back('{mk_tri(-1, -1, -5, 0, 1, -5, 1, -1, -5), 1'b0, miss});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (reset_rows[i])
         send(reset_rows[i].shape, reset_rows[i].typed, reset_rows[i].res, 1'b1);
      drain();

      // unused register index must leave the ray alone
      csr_write(REG_UNUSED, 32'hffffffff);
      set_ray('{q(0), q(0), q(-5)}, '{q(0), q(0), q(1)}, (CW-1)'(1));
      foreach (shape_rows[i]) send(shape_rows[i].shape, 1'b0, miss, 1'b1);
      drain();

      // tiny direction: distance saturates
      set_ray('{q(0), q(0), q(-5)}, '{coord_type'(0), coord_type'(0), coord_type'(1)},
              (CW-1)'(1));
      send(mk_tri(-3000, -3000, 30000, 0, 3000, 30000, 3000, -3000, 30000), 1'b0, miss, 1'b0);
      drain();
      // origin near the top: hit point saturates
      set_ray('{32'h7fff0000, 32'h7fff0000, 32'h7fff0000}, '{q(1), q(1), q(1)},
              (CW-1)'(1));
      send(tri_type'({32'h7fff0000, 32'h7fff0000, 32'h7fff8000 + 32'd0,
                      32'h7fff0000, 32'h7fff0000, 32'h7fff0000,
                      32'h7fff0000, 32'h7fff0000, 32'h7fff0000}), 1'b0, miss, 1'b0);
      send(around_ray(1 << 20, 1'b0), 1'b0, miss, 1'b0);
      drain();

      // random settings, each followed by a full drain
      for (int ph = 0; ph < 8; ph++) begin
         spread = 1 << 20;
         md = (CW-1)'(1);
         case (ph)
            0, 4: begin
               o = rand_pt(100 << FB);
               d = rand_pt(4 << FB);
            end
            1: begin
               o = rand_pt(10 << FB);
               d = rand_pt(2 << FB);
               md = 31'h7fffffff;
               spread = 1 << 28;
            end
            2: begin
               o = rand_pt(100 << FB);
               d = rand_pt(3);
            end
            3: begin
               o = '{edge_val(), edge_val(), edge_val()};
               d = '{edge_val(), edge_val(), edge_val()};
            end
            5: begin
               o = rand_pt(1000 << FB);
               d = rand_pt(8 << FB);
               md = (CW-1)'($urandom_range(1 << 16));
            end
            6: begin
               o = '{coord_type'($urandom), coord_type'($urandom), coord_type'($urandom)};
               d = '{coord_type'($urandom), coord_type'($urandom), coord_type'($urandom)};
               md = (CW-1)'($urandom);
            end
            default: begin
               o = rand_pt(50 << FB);
               d = rand_pt(1 << FB);
               md = (CW-1)'($urandom_range(1 << 12));
               spread = 1 << 24;
            end
         endcase
         set_ray(o, d, md);
         for (int n = 0; n < 215; n++) begin
            if ($urandom_range(99) < 80)
               t = around_ray($urandom_range(spread, 1 << 8), ph == 2);
            else
               t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
            send(t, 1'b0, miss, ($urandom_range(3) != 0) || (ph % 2 == 0));
         end
         drain();
      end

      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("ray_triangle_intersect_tb: PASS");
      end else begin
         $display("ray_triangle_intersect_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect.sv
dv/ray_triangle_intersect_tb.sv
